// ===== hdl/kcl_pkg.sv =====
// Package for the keypad code lock: key codes, phase and event codes,
// digit and status types, and the default code. No dependencies.
package kcl_pkg;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic equal;
	} cmp_status_t;

	localparam digit_t KEY_STAR = 4'd10;
	localparam digit_t KEY_HASH = 4'd11;
	localparam logic [3:0] FAIL_DEFAULT = 4'd3;
	localparam logic [3:0] FAIL_SAT = 4'd15;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ENTRY = 3'd1;
	localparam logic [2:0] PH_OLD = 3'd2;
	localparam logic [2:0] PH_NEW = 3'd3;
	localparam logic [2:0] PH_CONFIRM = 3'd4;
	localparam logic [2:0] PH_LOCKED = 3'd5;

	localparam logic [3:0] EV_IGNORED = 4'd0;
	localparam logic [3:0] EV_ENTRY_START = 4'd1;
	localparam logic [3:0] EV_CHANGE_START = 4'd2;
	localparam logic [3:0] EV_KEY_TAKEN = 4'd3;
	localparam logic [3:0] EV_ACCEPTED = 4'd4;
	localparam logic [3:0] EV_REJECTED = 4'd5;
	localparam logic [3:0] EV_LOCKOUT = 4'd6;
	localparam logic [3:0] EV_OLD_WRONG = 4'd7;
	localparam logic [3:0] EV_OLD_OK = 4'd8;
	localparam logic [3:0] EV_NEW_TAKEN = 4'd9;
	localparam logic [3:0] EV_CHANGED = 4'd10;
	localparam logic [3:0] EV_CONFIRM_BAD = 4'd11;

	// The code after reset is 1,2,3,4,5,6, with zeros beyond the sixth digit.
	function automatic digit_t default_digit(input int unsigned pos);
		digit_t d;
		d = 4'd0;
		if (pos < 6)
			d = 4'(pos + 1);
		return d;
	endfunction

endpackage

// ===== hdl/kcl_cmp.sv =====
// Shared digit compare unit of the keypad code lock: walks both codes one
// digit per cycle and reports whether all digits agree. Uses kcl_pkg.
module kcl_cmp #(
	parameter int CODE_LENGTH = 6,
	parameter int PW = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  kcl_pkg::digit_t       a_digit,
	input  kcl_pkg::digit_t       b_digit,
	output logic [PW-1:0]         idx,
	output kcl_pkg::cmp_status_t  status
);

	localparam logic [PW-1:0] LAST = PW'(CODE_LENGTH - 1);

	logic          busy_q;
	logic          done_q;
	logic          eq_q;
	logic [PW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			eq_q <= 1'b0;
			idx_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				eq_q <= 1'b1;
				idx_q <= '0;
			end else if (busy_q) begin
				eq_q <= eq_q & (a_digit == b_digit);
				if (idx_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign idx = idx_q;
	assign status = '{busy: busy_q, done: done_q, equal: eq_q};

endmodule

// ===== hdl/keypad_code_lock.sv =====
// Keypad code lock top: key sequencer, code stores, result register. Uses kcl_pkg, kcl_cmp.
// A key that does not finish a code goes from idle to the done state; the result register loads from there.
// Finishing an entry, old code or confirmation first waits in the compare state, the compare
// unit checking one digit per cycle. A confirmed code change then copies the new code into
// the store; a stalled result holds the done state, and no key is taken until it leaves.
// Reset (arst_n low, asynchronous) returns to idle, code 1..6, no failures, limit 3.
module keypad_code_lock #(
	parameter int CODE_LENGTH = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] key,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] event_res,
	output logic       open_door,
	output logic       alarm,
	output logic [3:0] failure_count,
	output logic [2:0] digits_entered,
	output logic [2:0] phase,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] max_failures
);

	localparam int PW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(CODE_LENGTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP = 2'd1;
	localparam logic [1:0] ST_COPY = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]      st_q;
	logic [2:0]      phase_q;
	logic [PW-1:0]   pos_q;
	logic [PW-1:0]   cp_q;
	logic [3:0]      fail_q;
	logic [3:0]      max_fail_q;
	logic [3:0]      ev_q;
	logic            door_q;
	logic            out_valid_q;
	logic [3:0]      event_q;
	logic            open_q;
	logic [3:0]      count_q;
	logic [2:0]      digits_q;
	logic [2:0]      phase_out_q;

	kcl_pkg::digit_t entry_q [CODE_LENGTH];
	kcl_pkg::digit_t pending_q [CODE_LENGTH];
	kcl_pkg::digit_t stored_q [CODE_LENGTH];

	logic                 accept;
	logic                 last_key;
	logic                 cmp_start;
	logic                 load_out;
	logic [3:0]           fail_inc;
	logic [PW+2:0]        pos_ext;
	logic [PW-1:0]        cmp_idx;
	kcl_pkg::digit_t      b_digit;
	kcl_pkg::cmp_status_t cmp_st;

	assign accept = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign last_key = (pos_q == LAST);
	assign cmp_start = accept && last_key &&
		(phase_q == kcl_pkg::PH_ENTRY || phase_q == kcl_pkg::PH_OLD ||
		 phase_q == kcl_pkg::PH_CONFIRM);
	assign load_out = (st_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign fail_inc = (fail_q == kcl_pkg::FAIL_SAT) ? fail_q : fail_q + 4'd1;
	assign pos_ext = {3'b000, pos_q};
	assign b_digit = (phase_q == kcl_pkg::PH_CONFIRM) ? pending_q[cmp_idx] : stored_q[cmp_idx];

	kcl_cmp #(
		.CODE_LENGTH(CODE_LENGTH),
		.PW(PW)
	) u_cmp (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmp_start),
		.a_digit(entry_q[cmp_idx]),
		.b_digit(b_digit),
		.idx(cmp_idx),
		.status(cmp_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fail_q <= kcl_pkg::FAIL_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			max_fail_q <= max_failures;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q != kcl_pkg::PH_IDLE && phase_q != kcl_pkg::PH_LOCKED) begin
			if (phase_q == kcl_pkg::PH_NEW)
				pending_q[pos_q] <= key;
			else
				entry_q[pos_q] <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CODE_LENGTH; i++)
				stored_q[i] <= kcl_pkg::default_digit(i);
		end else if (st_q == ST_COPY) begin
			stored_q[cp_q] <= pending_q[cp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= kcl_pkg::PH_IDLE;
			pos_q <= '0;
			cp_q <= '0;
			fail_q <= '0;
			ev_q <= kcl_pkg::EV_IGNORED;
			door_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						door_q <= 1'b0;
						st_q <= ST_DONE;
						case (phase_q) inside
							kcl_pkg::PH_IDLE: begin
								pos_q <= '0;
								if (key == kcl_pkg::KEY_STAR) begin
									phase_q <= kcl_pkg::PH_ENTRY;
									ev_q <= kcl_pkg::EV_ENTRY_START;
								end else if (key == kcl_pkg::KEY_HASH) begin
									phase_q <= kcl_pkg::PH_OLD;
									ev_q <= kcl_pkg::EV_CHANGE_START;
								end else begin
									ev_q <= kcl_pkg::EV_IGNORED;
								end
							end
							kcl_pkg::PH_ENTRY, kcl_pkg::PH_OLD, kcl_pkg::PH_NEW,
							kcl_pkg::PH_CONFIRM: begin
								if (!last_key) begin
									pos_q <= pos_q + 1'b1;
									ev_q <= kcl_pkg::EV_KEY_TAKEN;
								end else begin
									pos_q <= '0;
									if (phase_q == kcl_pkg::PH_NEW) begin
										phase_q <= kcl_pkg::PH_CONFIRM;
										ev_q <= kcl_pkg::EV_NEW_TAKEN;
									end else begin
										st_q <= ST_CMP;
									end
								end
							end
							default: begin
								phase_q <= kcl_pkg::PH_LOCKED;
								ev_q <= kcl_pkg::EV_IGNORED;
							end
						endcase
					end
				end
				ST_CMP: begin
					if (cmp_st.done) begin
						st_q <= ST_DONE;
						phase_q <= kcl_pkg::PH_IDLE;
						case (phase_q)
							kcl_pkg::PH_ENTRY: begin
								if (cmp_st.equal) begin
									ev_q <= kcl_pkg::EV_ACCEPTED;
									door_q <= 1'b1;
									fail_q <= '0;
								end else begin
									fail_q <= fail_inc;
									if (fail_inc >= max_fail_q) begin
										ev_q <= kcl_pkg::EV_LOCKOUT;
										phase_q <= kcl_pkg::PH_LOCKED;
									end else begin
										ev_q <= kcl_pkg::EV_REJECTED;
									end
								end
							end
							kcl_pkg::PH_OLD: begin
								if (cmp_st.equal) begin
									ev_q <= kcl_pkg::EV_OLD_OK;
									phase_q <= kcl_pkg::PH_NEW;
								end else begin
									ev_q <= kcl_pkg::EV_OLD_WRONG;
								end
							end
							default: begin
								if (cmp_st.equal) begin
									ev_q <= kcl_pkg::EV_CHANGED;
									cp_q <= '0;
									st_q <= ST_COPY;
								end else begin
									ev_q <= kcl_pkg::EV_CONFIRM_BAD;
								end
							end
						endcase
					end
				end
				ST_COPY: begin
					if (cp_q == LAST)
						st_q <= ST_DONE;
					else
						cp_q <= cp_q + 1'b1;
				end
				ST_DONE: begin
					if (load_out)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			event_q <= ev_q;
			open_q <= door_q;
			count_q <= fail_q;
			digits_q <= pos_ext[2:0];
			phase_out_q <= phase_q;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign open_door = open_q;
	assign alarm = (phase_out_q == kcl_pkg::PH_LOCKED);
	assign failure_count = count_q;
	assign digits_entered = digits_q;
	assign phase = phase_out_q;

	// The door only opens on a transaction that reports an accepted code.
	a_door_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_door |-> event_res == kcl_pkg::EV_ACCEPTED)
		else $error("open_door without accepted event");

	// While the sequencer waits on a comparison, the compare unit is working.
	a_cmp_active: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CMP |-> (cmp_st.busy || cmp_st.done))
		else $error("compare wait with idle compare unit");

	// A new result only appears after the sequencer has finished an item.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == ST_DONE)
		else $error("result raised outside the done state");

	// A locked block never leaves the locked phase.
	a_lock_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == kcl_pkg::PH_LOCKED |=> phase_q == kcl_pkg::PH_LOCKED)
		else $error("left the locked phase without reset");

endmodule

// ===== test/keypad_code_lock_tb.sv =====
// Self-checking testbench for keypad_code_lock: directed key table, then random code
// entries and code changes under several failure limits, ending in lockout.
// Depends on kcl_pkg and the keypad_code_lock RTL.
module keypad_code_lock_tb;

	localparam int CODE_LEN = 6;
	localparam int PHASE_ITEMS = 380;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int DIR_ROWS = 27;

	typedef kcl_pkg::digit_t [CODE_LEN-1:0] code_t;

	typedef struct packed {
		logic [3:0] ev;
		logic       door;
		logic       alarm;
		logic [3:0] fails;
		logic [2:0] digits;
		logic [2:0] ph;
	} lock_res_t;

	typedef struct packed {
		kcl_pkg::digit_t key;
		logic            typed;
		logic [3:0]      ev;
		logic [2:0]      ph;
	} key_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [3:0] key;
	logic       out_valid;
	logic       out_stall;
	logic [3:0] event_res;
	logic       open_door;
	logic       alarm;
	logic [3:0] failure_count;
	logic [2:0] digits_entered;
	logic [2:0] phase;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] max_failures;

	lock_res_t due_results[$];
	int errors = 0;
	int results_seen = 0;

	logic [2:0] lk_phase;
	int         lk_pos;
	code_t      lk_entry;
	code_t      lk_pending;
	code_t      lk_code;
	logic [3:0] lk_fails;
	logic [3:0] lk_limit;
	code_t      key_plan;

	keypad_code_lock #(
		.CODE_LENGTH(CODE_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.open_door(open_door),
		.alarm(alarm),
		.failure_count(failure_count),
		.digits_entered(digits_entered),
		.phase(phase),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_failures(max_failures)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic code_done();
		lk_pos++;
		if (lk_pos >= CODE_LEN) begin
			lk_pos = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic code_t alter_code(input code_t c);
		c[$urandom_range(0, CODE_LEN - 1)] = 4'($urandom_range(0, 15));
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	task automatic apply_key(input kcl_pkg::digit_t k, output lock_res_t r);
		r = '0;
		case (lk_phase)
			kcl_pkg::PH_IDLE: begin
				if (k == kcl_pkg::KEY_STAR) begin
					lk_phase = kcl_pkg::PH_ENTRY;
					lk_pos = 0;
					r.ev = kcl_pkg::EV_ENTRY_START;
				end else if (k == kcl_pkg::KEY_HASH) begin
					lk_phase = kcl_pkg::PH_OLD;
					lk_pos = 0;
					r.ev = kcl_pkg::EV_CHANGE_START;
				end
			end
			kcl_pkg::PH_ENTRY: begin
				lk_entry[lk_pos] = k;
				if (!code_done()) begin
					r.ev = kcl_pkg::EV_KEY_TAKEN;
				end else if (lk_entry == lk_code) begin
					r.ev = kcl_pkg::EV_ACCEPTED;
					r.door = 1'b1;
					lk_fails = 4'd0;
					lk_phase = kcl_pkg::PH_IDLE;
				end else begin
					if (lk_fails != kcl_pkg::FAIL_SAT)
						lk_fails++;
					if (lk_fails >= lk_limit) begin
						r.ev = kcl_pkg::EV_LOCKOUT;
						lk_phase = kcl_pkg::PH_LOCKED;
					end else begin
						r.ev = kcl_pkg::EV_REJECTED;
						lk_phase = kcl_pkg::PH_IDLE;
					end
				end
			end
			kcl_pkg::PH_OLD: begin
				lk_entry[lk_pos] = k;
				if (!code_done()) begin
					r.ev = kcl_pkg::EV_KEY_TAKEN;
				end else if (lk_entry == lk_code) begin
					r.ev = kcl_pkg::EV_OLD_OK;
					lk_phase = kcl_pkg::PH_NEW;
				end else begin
					r.ev = kcl_pkg::EV_OLD_WRONG;
					lk_phase = kcl_pkg::PH_IDLE;
				end
			end
			kcl_pkg::PH_NEW: begin
				lk_pending[lk_pos] = k;
				if (!code_done()) begin
					r.ev = kcl_pkg::EV_KEY_TAKEN;
				end else begin
					r.ev = kcl_pkg::EV_NEW_TAKEN;
					lk_phase = kcl_pkg::PH_CONFIRM;
				end
			end
			kcl_pkg::PH_CONFIRM: begin
				lk_entry[lk_pos] = k;
				if (!code_done()) begin
					r.ev = kcl_pkg::EV_KEY_TAKEN;
				end else begin
					if (lk_entry == lk_pending) begin
						lk_code = lk_pending;
						r.ev = kcl_pkg::EV_CHANGED;
					end else begin
						r.ev = kcl_pkg::EV_CONFIRM_BAD;
					end
					lk_phase = kcl_pkg::PH_IDLE;
				end
			end
			default: begin
				lk_phase = kcl_pkg::PH_LOCKED;
			end
		endcase
		r.alarm = (lk_phase == kcl_pkg::PH_LOCKED);
		r.fails = lk_fails;
		r.digits = 3'(lk_pos);
		r.ph = lk_phase;
	endtask

	// A wrong entry that would lock the block is replaced by the stored code, so the
	// lockout is kept for the end of the run.
	task automatic next_key(output kcl_pkg::digit_t k);
		int r;
		logic [3:0] next_fails;
		r = $urandom_range(0, 99);
		if (lk_phase == kcl_pkg::PH_IDLE) begin
			if (r < 45)
				k = kcl_pkg::KEY_STAR;
			else if (r < 80)
				k = kcl_pkg::KEY_HASH;
			else
				k = 4'($urandom_range(0, 15));
		end else begin
			if (lk_pos == 0) begin
				case (lk_phase)
					kcl_pkg::PH_ENTRY: begin
						next_fails = (lk_fails == kcl_pkg::FAIL_SAT) ?
							kcl_pkg::FAIL_SAT : lk_fails + 4'd1;
						if (next_fails >= lk_limit || r < 55)
							key_plan = lk_code;
						else if (r < 80)
							key_plan = alter_code(lk_code);
						else
							key_plan = 24'($urandom());
					end
					kcl_pkg::PH_OLD: begin
						if (r < 75)
							key_plan = lk_code;
						else if (r < 90)
							key_plan = alter_code(lk_code);
						else
							key_plan = 24'($urandom());
					end
					kcl_pkg::PH_CONFIRM: begin
						if (r < 70)
							key_plan = lk_pending;
						else
							key_plan = alter_code(lk_pending);
					end
					default: begin
						key_plan = 24'($urandom());
					end
				endcase
			end
			k = key_plan[lk_pos];
		end
	endtask

	task automatic idle_gap();
		int n;
		n = pick_gap();
		repeat (n) @(negedge clk) in_valid <= 1'b0;
	endtask

	task automatic send_key(input kcl_pkg::digit_t k, input logic typed, input logic [3:0] ev,
			input logic [2:0] ph, output lock_res_t r);
		@(negedge clk);
		in_valid <= 1'b1;
		key <= k;
		do @(posedge clk); while (in_stall);
		apply_key(k, r);
		if (typed) begin
			r.ev = ev;
			r.ph = ph;
		end
		due_results.push_back(r);
	endtask

	task automatic write_limit(input logic [3:0] v);
		@(negedge clk) in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (2 * CODE_LEN + 3) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		max_failures <= v;
		do @(posedge clk); while (!cfg_ready);
		lk_limit = v;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		key_row_t rows [DIR_ROWS];
		lock_res_t r;
		kcl_pkg::digit_t k;
		code_t wrong;
		int counted;
		int limits [5];
		arst_n = 1'b0;
		in_valid = 1'b0;
		key = 4'd0;
		cfg_valid = 1'b0;
		max_failures = kcl_pkg::FAIL_DEFAULT;
		lk_phase = kcl_pkg::PH_IDLE;
		lk_pos = 0;
		lk_fails = 4'd0;
		lk_limit = kcl_pkg::FAIL_DEFAULT;
		lk_entry = '0;
		lk_pending = '0;
		for (int i = 0; i < CODE_LEN; i++)
			lk_code[i] = 4'(i + 1);
		rows = '{
			'{4'd15,             1'b1, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_STAR, 1'b1, kcl_pkg::EV_ENTRY_START,  kcl_pkg::PH_ENTRY},
			'{4'd15,             1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_HASH, 1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_STAR, 1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd0,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd12,             1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd9,              1'b1, kcl_pkg::EV_REJECTED,     kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_HASH, 1'b1, kcl_pkg::EV_CHANGE_START, kcl_pkg::PH_OLD},
			'{4'd1,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd2,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd3,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd4,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd5,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd6,              1'b1, kcl_pkg::EV_OLD_OK,       kcl_pkg::PH_NEW},
			'{4'd9,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd0,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd15,             1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_HASH, 1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_STAR, 1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd7,              1'b1, kcl_pkg::EV_NEW_TAKEN,    kcl_pkg::PH_CONFIRM},
			'{4'd9,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd0,              1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd15,             1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_HASH, 1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{kcl_pkg::KEY_STAR, 1'b0, kcl_pkg::EV_IGNORED,      kcl_pkg::PH_IDLE},
			'{4'd7,              1'b1, kcl_pkg::EV_CHANGED,      kcl_pkg::PH_IDLE}
		};
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (rows[i]) begin
			idle_gap();
			send_key(rows[i].key, rows[i].typed, rows[i].ev, rows[i].ph, r);
		end

		limits = '{1, $urandom_range(2, 14), 2, $urandom_range(1, 15), 15};
		foreach (limits[p]) begin
			write_limit(4'(limits[p]));
			counted = 0;
			while (counted < PHASE_ITEMS || lk_phase != kcl_pkg::PH_IDLE) begin
				next_key(k);
				idle_gap();
				send_key(k, 1'b0, kcl_pkg::EV_IGNORED, kcl_pkg::PH_IDLE, r);
				if (r.ev != kcl_pkg::EV_IGNORED)
					counted++;
			end
		end

		// A limit of zero locks on the first failed entry; afterwards every key is ignored.
		write_limit(4'd0);
		wrong = lk_code;
		wrong[0] = wrong[0] ^ 4'd1;
		idle_gap();
		send_key(kcl_pkg::KEY_STAR, 1'b0, kcl_pkg::EV_IGNORED, kcl_pkg::PH_IDLE, r);
		for (int i = 0; i < CODE_LEN; i++) begin
			idle_gap();
			send_key(wrong[i], 1'b0, kcl_pkg::EV_IGNORED, kcl_pkg::PH_IDLE, r);
		end
		repeat (8) begin
			idle_gap();
			send_key(4'($urandom_range(0, 15)), 1'b0, kcl_pkg::EV_IGNORED,
				kcl_pkg::PH_IDLE, r);
		end

		@(negedge clk) in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("keypad_code_lock: match");
		else
			$display("keypad_code_lock: mismatch");
		$finish;
	end

	initial begin : result_stall
		int n;
		logic held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			n = pick_gap();
			repeat (n) @(negedge clk) out_stall <= 1'b1;
			n = $urandom_range(1, 30);
			repeat (n) @(negedge clk) out_stall <= 1'b0;
			if (!held && results_seen >= 200) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
			end
		end
	end

	initial begin : result_check
		lock_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("result %0d with no transaction outstanding, event_res %0d",
						results_seen, event_res));
				end else begin
					want = due_results.pop_front();
					if (event_res !== want.ev)
						report_mismatch($sformatf("result %0d event_res %0d, expected %0d",
							results_seen, event_res, want.ev));
					if (open_door !== want.door)
						report_mismatch($sformatf("result %0d open_door %0d, expected %0d",
							results_seen, open_door, want.door));
					if (alarm !== want.alarm)
						report_mismatch($sformatf("result %0d alarm %0d, expected %0d",
							results_seen, alarm, want.alarm));
					if (failure_count !== want.fails)
						report_mismatch($sformatf("result %0d failure_count %0d, expected %0d",
							results_seen, failure_count, want.fails));
					if (digits_entered !== want.digits)
						report_mismatch($sformatf("result %0d digits_entered %0d, expected %0d",
							results_seen, digits_entered, want.digits));
					if (phase !== want.ph)
						report_mismatch($sformatf("result %0d phase %0d, expected %0d",
							results_seen, phase, want.ph));
				end
				results_seen++;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("keypad_code_lock: mismatch");
		$finish;
	end

endmodule
